FILE: sv/circle_points_on_plane_core_defines.svh
// Assertion macros shared by the checker.
`ifndef CIRCLE_POINTS_ON_PLANE_CORE_DEFINES_SVH
`define CIRCLE_POINTS_ON_PLANE_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define CPP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: sv/cpp_pkg.sv
// ----------------------------------------------------------------------------
// cpp_pkg
// Types, constants and helpers shared by the circle point generator.
// ----------------------------------------------------------------------------
package cpp_pkg;

  localparam int MaxSegmentsDefault = 64;
  localparam int CordicStepsDefault = 16;
  localparam int AtanDepth          = 24;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] OneQ30     = 34'sd1073741824;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic        [30:0] radius;
    logic        [6:0]  segments;
  } req_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_z;
    logic               last_point;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_PREP, ST_CORDIC, ST_ROT, ST_MUL_X, ST_MUL_Z,
    ST_SUM, ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend_hi;
    logic [6:0]  divisor;
  } div_cmd_t;

  function automatic logic [31:0] atan_lookup(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B; 5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53; 5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9; 5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/cpp_divider.sv
// ----------------------------------------------------------------------------
// cpp_divider
// Bit-serial restoring divider: floor((k*2^32 + floor(N/2)) / N), one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpp_divider
  import cpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_cmd_t    cmd,
  output logic        busy,
  output logic [31:0] quotient
);

  // Dividend is {k, 32'b0} + floor(N/2); only the low 32 quotient bits matter.
  logic [63:0] dividend;
  logic [7:0]  rem;
  logic [5:0]  count;
  logic [7:0]  trial;

  assign trial = {rem[6:0], dividend[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (cmd.start) begin
      busy     <= 1'b1;
      count    <= 6'd63;
      rem      <= '0;
      dividend <= {cmd.dividend_hi, 26'd0, cmd.divisor[6:1]};
    end else if (busy) begin
      dividend <= {dividend[62:0], 1'b0};
      if (trial >= {1'b0, cmd.divisor}) begin
        rem      <= trial - {1'b0, cmd.divisor};
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= trial;
        quotient <= {quotient[30:0], 1'b0};
      end
      if (count == '0) begin
        busy <= 1'b0;
      end
      count <= count - 6'd1;
    end
  end

endmodule

FILE: sv/cpp_cordic.sv
// ----------------------------------------------------------------------------
// cpp_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, with quadrant fold.
// ----------------------------------------------------------------------------
module cpp_cordic
  import cpp_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         phase,
  output logic                busy,
  output logic signed [33:0]  sin_q30,
  output logic signed [33:0]  cos_q30
);

  localparam int IW = $clog2(CORDIC_STEPS + 1);

  logic signed [33:0] x, y, z;
  logic [1:0]         quad;
  logic [IW-1:0]      step;
  logic [31:0]        qsum;
  logic [31:0]        resid;
  logic signed [33:0] dx, dy, at, c, s;

  assign qsum  = phase + 32'h20000000;
  assign resid = phase - {qsum[31:30], 30'd0};
  assign dx    = y >>> step;
  assign dy    = x >>> step;
  assign at    = $signed({2'b00, atan_lookup(5'(step))});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      quad <= qsum[31:30];
      x    <= CordicGain;
      y    <= '0;
      z    <= 34'($signed(resid));
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - dx; y <= y + dy; z <= z - at;
      end else begin
        x <= x + dx; y <= y - dy; z <= z + at;
      end
      if (step == IW'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
      end
      step <= step + IW'(1);
    end
  end

  always_comb begin
    unique case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    cos_q30 = (c > OneQ30) ? OneQ30 : ((c < -OneQ30) ? -OneQ30 : c);
    sin_q30 = (s > OneQ30) ? OneQ30 : ((s < -OneQ30) ? -OneQ30 : s);
  end

endmodule

FILE: sv/circle_points_on_plane_core.sv
// ----------------------------------------------------------------------------
// circle_points_on_plane_core
// Emits the points and normals of a horizontal circle, one per segment.
// ----------------------------------------------------------------------------
// Channel | Signals                    | Payload
// req     | req_valid / req_ready      | req_t (centre, radius, segments)
// res     | res_valid / res_ready      | res_t (point, normal, last flag)
//
// Each point runs through these steps: the sequencer starts the divider, the
// bit-serial divider forms the phase, the CORDIC unit forms sine and cosine,
// and the sequencer then latches them, multiplies twice, sums and presents
// the result. One request is handled at a time; a stalled result holds the
// sequencer. Reset (synchronous) returns the sequencer to idle.
// ----------------------------------------------------------------------------
module circle_points_on_plane_core
  import cpp_pkg::*;
#(
  parameter int MAX_SEGMENTS = MaxSegmentsDefault,
  parameter int CORDIC_STEPS = CordicStepsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  state_t state, state_next;
  req_t   held;
  logic [6:0] seg_n, k;
  div_cmd_t dcmd;
  logic div_busy, cor_busy, cor_start;
  logic [31:0] mag;
  logic signed [33:0] sin_v, cos_v;
  logic signed [33:0] sin_r, cos_r;
  logic signed [65:0] prod;
  logic signed [33:0] sx, sz;
  logic signed [33:0] off;
  logic [6:0] nreq;

  assign nreq = (req.segments > 7'(MAX_SEGMENTS)) ? 7'(MAX_SEGMENTS) : req.segments;
  assign dcmd.start       = (state == ST_PREP);
  assign dcmd.dividend_hi = {25'd0, k};
  assign dcmd.divisor     = seg_n;
  assign cor_start        = (state == ST_DIV) && !div_busy && !dcmd.start;

  cpp_divider u_div (
    .clk(clk), .rst(rst), .cmd(dcmd), .busy(div_busy), .quotient(mag)
  );

  cpp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .phase(32'd0 - mag),
    .busy(cor_busy), .sin_q30(sin_v), .cos_q30(cos_v)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid && req.segments != 7'd0) state_next = ST_PREP;
      end
      ST_PREP:   state_next = ST_DIV;
      ST_DIV:    if (!div_busy) state_next = ST_CORDIC;
      ST_CORDIC: if (!cor_busy) state_next = ST_ROT;
      ST_ROT:    state_next = ST_MUL_X;
      ST_MUL_X:  state_next = ST_MUL_Z;
      ST_MUL_Z:  state_next = ST_SUM;
      ST_SUM:    state_next = ST_OUT;
      ST_OUT: begin
        if (res_ready) state_next = (k == seg_n - 7'd1) ? ST_IDLE : ST_PREP;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // One 32x34 multiply per cycle, shared by the x and z offsets.
  assign prod = $signed({1'b0, held.radius}) * (state == ST_MUL_X ? sin_r : cos_r);
  assign off  = 34'((prod + 66'sd536870912) >>> 30);

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'h7FFFFFFF;
    if (v < -34'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd32768) >>> 16;
    if (t > 34'sd16384) return 16'sd16384;
    if (t < -34'sd16384) return -16'sd16384;
    return t[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      held  <= req;
      seg_n <= nreq;
      k     <= '0;
    end
    if (state == ST_ROT) begin
      sin_r <= sin_v;
      cos_r <= cos_v;
    end
    if (state == ST_MUL_X) sx <= 34'($signed(held.center_x)) + off;
    if (state == ST_MUL_Z) sz <= 34'($signed(held.center_z)) + off;
    if (state == ST_SUM) begin
      res.point_x    <= sat32(sx);
      res.point_y    <= held.center_y;
      res.point_z    <= sat32(sz);
      res.normal_x   <= to_q14(sin_r);
      res.normal_z   <= to_q14(cos_r);
      res.last_point <= (k == seg_n - 7'd1);
    end
    if (state == ST_OUT && res_ready) k <= k + 7'd1;
  end

  assign res_valid = (state == ST_OUT);

endmodule

FILE: sv/cpp_checker.sv
// ----------------------------------------------------------------------------
// cpp_checker
// Port-level checks on the circle point generator.
// ----------------------------------------------------------------------------
`include "circle_points_on_plane_core_defines.svh"
module cpp_checker
  import cpp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic res_valid,
  input logic res_ready,
  input res_t res
);

  `CPP_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")
  `CPP_ASSERT_IMPL(a_busy_excl, clk, rst, res_valid, !req_ready, "request taken while a result is pending")
  `CPP_ASSERT_NEXT(a_take_quiet, clk, rst, req_valid && req_ready, !res_valid, "result without work")
  `CPP_ASSERT_NEXT(a_last_idle, clk, rst, res_valid && res_ready && res.last_point, !res_valid, "result after the last point")

endmodule

bind circle_points_on_plane_core cpp_checker u_cpp_checker (.*);

FILE: tb/tb_circle_points_on_plane_core.sv
// ----------------------------------------------------------------------------
// tb_circle_points_on_plane_core
// Drives circle requests, some with random gaps, and checks every emitted point,
// normal and last flag against a CORDIC predictor kept in the testbench.
// ----------------------------------------------------------------------------
module tb_circle_points_on_plane_core;
  import cpp_pkg::*;

  localparam int MaxSeg = 64;
  localparam int Steps = 16;
  localparam longint CycleLimit = 64'd40000000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic res_valid;
  logic res_ready;
  res_t res;

  res_t point_queue[$];
  int unsigned fail_count;
  longint cycle_count;
  bit hold_off;
  int hold_cycles;
  int ready_wait;

  circle_points_on_plane_core i_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint shr_floor(input longint v, input int n);
    return v >>> n;
  endfunction

  function automatic longint clampl(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic signed [15:0] to_normal(input longint v);
    return 16'(clampl(shr_floor(v + 32768, 16), -16384, 16384));
  endfunction

  function automatic logic signed [31:0] offset_coord(input longint ctr, input longint r,
                                                      input longint trig);
    longint off;
    off = shr_floor(r * trig + (64'sd1 <<< 29), 30);
    return 32'(clampl(ctr + off, -64'sd2147483648, 64'sd2147483647));
  endfunction

  // Rotation-mode CORDIC on the residual angle, then folded by quadrant.
  task automatic sine_cosine(input logic [31:0] phase, output longint s, output longint c);
    logic [31:0] q;
    logic [31:0] resid;
    longint x, y, z, dx, dy;
    q = ((phase + 32'h20000000) >> 30) & 32'd3;
    resid = phase - (q << 30);
    z = longint'(signed'(resid));
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_lookup(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_lookup(5'(i)));
      end
    end
    case (q)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    s = clampl(s, -64'sd1073741824, 64'sd1073741824);
    c = clampl(c, -64'sd1073741824, 64'sd1073741824);
  endtask

  task automatic predict_circle(input req_t rq);
    int n;
    longint unsigned mag;
    logic [31:0] phase;
    longint s, c;
    res_t p;
    n = rq.segments;
    if (n == 0) return;
    if (n > MaxSeg) n = MaxSeg;
    for (int k = 0; k < n; k++) begin
      mag = ((longint'(k) << 32) + (n >> 1)) / n;
      phase = 32'(0) - 32'(mag);
      sine_cosine(phase, s, c);
      p.point_x = offset_coord(longint'(rq.center_x), longint'(rq.radius), s);
      p.point_y = rq.center_y;
      p.point_z = offset_coord(longint'(rq.center_z), longint'(rq.radius), c);
      p.normal_x = to_normal(s);
      p.normal_z = to_normal(c);
      p.last_point = (k == n - 1);
      point_queue.push_back(p);
    end
  endtask

  // Valid is dropped only when a gap follows, so back-to-back offers stay high.
  task automatic send_request(input req_t rq, input bit gaps);
    int wait_cycles;
    wait_cycles = gaps ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (wait_cycles != 0) begin
      req_valid <= 1'b0;
      repeat (wait_cycles) @(negedge clk);
    end
    req <= rq;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_circle(rq);
  endtask

  function automatic req_t random_request(input bit wide_sizes);
    req_t rq;
    rq.center_x = $urandom;
    rq.center_y = $urandom;
    rq.center_z = $urandom;
    rq.radius = 31'($urandom);
    case ($urandom_range(0, 3))
      0: rq.center_x = 32'($urandom_range(0, 2000)) - 1000;
      1: rq.radius = 31'($urandom_range(0, 1 << 20));
      default: ;
    endcase
    if (wide_sizes) rq.segments = 7'($urandom);
    else rq.segments = 7'($urandom_range(1, 6));
    return rq;
  endfunction

  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (point_queue.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic test_directed();
    req_t rq;
    rq = '0;
    for (int n = 0; n <= 4; n++) begin
      rq.radius = 31'd65536; rq.segments = 7'(n);
      send_request(rq, 1'b0);
    end
    rq.center_x = 32'h7FFFFFFF; rq.center_y = 32'h80000000; rq.center_z = 32'h7FFFFFFF;
    rq.radius = 31'h7FFFFFFF; rq.segments = 7'd8;
    send_request(rq, 1'b1);
    rq.center_x = 32'h80000000; rq.center_y = 32'h7FFFFFFF; rq.center_z = 32'h80000000;
    rq.segments = 7'd7;
    send_request(rq, 1'b1);
    rq = '0; rq.segments = 7'd64;
    send_request(rq, 1'b1);
    rq.center_x = 32'hFFFFFFFF; rq.center_z = 32'h00010000; rq.radius = 31'd1;
    rq.segments = 7'd127;
    send_request(rq, 1'b1);
    rq.segments = 7'd65;
    send_request(rq, 1'b1);
    rq.segments = 7'd3;
    send_request(rq, 1'b1);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_request(random_request(($urandom_range(0, 29) == 0)), 1'b1);
  endtask

  // The receiver stops for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_cycles = 3000;
    hold_off = 1'b1;
    for (int i = 0; i < 4; i++) send_request(random_request(1'b0), 1'b0);
  endtask

  task automatic test_pause();
    drain_results();
    for (int i = 0; i < 6; i++) send_request(random_request(1'b0), 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    hold_off = 1'b0;
    hold_cycles = 0;
    fail_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_backpressure();
    test_pause();
    test_random(245);
    drain_results();
    if (fail_count == 0 && point_queue.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        res_ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_off = 1'b0;
      end
      if (res_ready && res_valid) begin
        // Transaction taken at the last edge: choose the next stall.
      end
      ready_wait = $urandom_range(0, 9);
      if (ready_wait != 0) begin
        res_ready <= 1'b0;
        repeat (ready_wait) @(negedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (point_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, res);
        fail_count++;
      end else begin
        want = point_queue.pop_front();
        if (res.point_x !== want.point_x) begin
          $display("%0t: point_x expected %0d actual %0d", $time, want.point_x, res.point_x);
          fail_count++;
        end
        if (res.point_y !== want.point_y) begin
          $display("%0t: point_y expected %0d actual %0d", $time, want.point_y, res.point_y);
          fail_count++;
        end
        if (res.point_z !== want.point_z) begin
          $display("%0t: point_z expected %0d actual %0d", $time, want.point_z, res.point_z);
          fail_count++;
        end
        if (res.normal_x !== want.normal_x) begin
          $display("%0t: normal_x expected %0d actual %0d", $time, want.normal_x,
                   res.normal_x);
          fail_count++;
        end
        if (res.normal_z !== want.normal_z) begin
          $display("%0t: normal_z expected %0d actual %0d", $time, want.normal_z,
                   res.normal_z);
          fail_count++;
        end
        if (res.last_point !== want.last_point) begin
          $display("%0t: last_point expected %0b actual %0b", $time, want.last_point,
                   res.last_point);
          fail_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
